// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// small assertion helpers for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: hw/rtl/ctc_pkg.sv
// ----------------------------------------------------------------------------
// ctc_pkg
// shared types and constants of the causal temporal convolution
// ----------------------------------------------------------------------------
package ctc_pkg;
    localparam int CHANNELS   = 8;
    localparam int KERNEL     = 3;
    localparam int FRAC_BITS  = 8;
    localparam int DATA_WIDTH = 16;
    localparam int NWEIGHTS   = CHANNELS * CHANNELS * KERNEL;
    localparam int WADDR_W    = $clog2(NWEIGHTS);
    localparam int ACC_W      = 2 * DATA_WIDTH + FRAC_BITS + 8;

    localparam logic [1:0] ACT_WEIGHT = 2'd0;
    localparam logic [1:0] ACT_BIAS   = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;

    typedef enum logic [1:0] {
        CMD_WEIGHT = 2'd0,
        CMD_BIAS   = 2'd1,
        CMD_SAMPLE = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [2:0]       out_chan;
        logic [2:0]       in_chan;
        logic [1:0]       tap;
        logic [15:0]      value;
        logic             seq_start;
    } cmd_t;
endpackage

// File: hw/rtl/ctc_front.sv
// ----------------------------------------------------------------------------
// ctc_front
// accepts input words, drops invalid ones, pushes commands into a queue
// ----------------------------------------------------------------------------
module ctc_front import ctc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  action,
    input  logic [2:0]  out_chan,
    input  logic [2:0]  in_chan,
    input  logic [1:0]  tap,
    input  logic [15:0] value,
    input  logic        seq_start,
    output logic        q_valid,
    input  logic        q_ready,
    output cmd_t        q_cmd
);
    cmd_t       mem_reg [4];
    logic [2:0] wp_reg, rp_reg;
    logic       keep;
    logic       push, pop;
    cmd_t       c;

    assign s_ready = (wp_reg - rp_reg) != 3'd4;
    assign q_valid = wp_reg != rp_reg;
    assign q_cmd   = mem_reg[rp_reg[1:0]];
    assign pop     = q_valid && q_ready;

    always_comb begin
        c.out_chan  = out_chan;
        c.in_chan   = in_chan;
        c.tap       = tap;
        c.value     = value;
        c.seq_start = seq_start;
        c.kind      = CMD_SAMPLE;
        keep        = 1'b0;
        unique case (action)
            ACT_WEIGHT: begin
                c.kind = CMD_WEIGHT;
                keep = (32'(out_chan) < CHANNELS) && (32'(in_chan) < CHANNELS)
                       && (32'(tap) < KERNEL);
            end
            ACT_BIAS: begin
                c.kind = CMD_BIAS;
                keep = 32'(out_chan) < CHANNELS;
            end
            ACT_SAMPLE: begin
                keep = 32'(in_chan) < CHANNELS;
            end
            default: keep = 1'b0;
        endcase
    end

    assign push = s_valid && s_ready && keep;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg[1:0]] <= c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 3'd1;
            if (pop)  rp_reg <= rp_reg + 3'd1;
        end
    end
endmodule

// File: hw/rtl/ctc_back.sv
// ----------------------------------------------------------------------------
// ctc_back
// executes commands: store loads, history update, mac sequencer
// ----------------------------------------------------------------------------
module ctc_back import ctc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  cmd_t        q_cmd,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  chan,
    output logic [15:0] result,
    output logic        last,
    output logic        busy
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MAC  = 4'b0010,
        ST_DONE = 4'b0100,
        ST_SHFT = 4'b1000
    } st_t;

    localparam int HN = CHANNELS * KERNEL;

    logic signed [15:0] wmem [NWEIGHTS];
    logic signed [15:0] bmem [CHANNELS];
    logic signed [15:0] hist_reg [HN];

    st_t                    st_reg;
    logic [2:0]             co_reg;
    logic [2:0]             ci_reg;
    logic [1:0]             k_reg;
    logic                   rd_v_reg;
    logic                   last_mac_reg;
    logic                   fin_reg;
    logic signed [15:0]     wrd_reg, hrd_reg, brd_reg;
    logic signed [31:0]     prod_reg;
    logic                   prod_v_reg, prod_last_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                   acc_first_reg;
    logic                   ov_reg;
    logic [2:0]             och_reg;
    logic [15:0]            ores_reg;
    logic                   olast_reg;

    logic [WADDR_W-1:0] waddr_w, raddr_w;
    logic [4:0]         hidx_w;
    logic               issue, end_issue;
    logic signed [ACC_W-1:0] sum_w;

    assign q_ready = (st_reg == ST_IDLE);
    assign busy    = (st_reg != ST_IDLE);
    assign waddr_w = WADDR_W'((32'(q_cmd.out_chan) * CHANNELS + 32'(q_cmd.in_chan)) * KERNEL
                              + 32'(q_cmd.tap));
    assign raddr_w = WADDR_W'((32'(co_reg) * CHANNELS + 32'(ci_reg)) * KERNEL + 32'(k_reg));
    assign hidx_w  = 5'(32'(ci_reg) * KERNEL + 32'(k_reg));
    assign issue   = (st_reg == ST_MAC);
    assign end_issue = issue && (32'(ci_reg) == CHANNELS - 1) && (32'(k_reg) == KERNEL - 1);

    always_ff @(posedge aclk) begin
        if (q_valid && q_ready && q_cmd.kind == CMD_WEIGHT) wmem[waddr_w] <= q_cmd.value;
        if (q_valid && q_ready && q_cmd.kind == CMD_BIAS) bmem[q_cmd.out_chan] <= q_cmd.value;
        wrd_reg <= wmem[raddr_w];
        hrd_reg <= hist_reg[hidx_w];
        brd_reg <= bmem[co_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HN; i++) hist_reg[i] <= '0;
        end else if (q_valid && q_ready && q_cmd.kind == CMD_SAMPLE) begin
            for (int c = 0; c < CHANNELS; c++)
                for (int k = 0; k < KERNEL - 1; k++)
                    if (q_cmd.seq_start) hist_reg[c * KERNEL + k] <= '0;
            hist_reg[32'(q_cmd.in_chan) * KERNEL + KERNEL - 1] <= q_cmd.value;
        end else if (st_reg == ST_SHFT) begin
            for (int c = 0; c < CHANNELS; c++)
                for (int k = 0; k < KERNEL - 1; k++)
                    hist_reg[c * KERNEL + k] <= hist_reg[c * KERNEL + k + 1];
        end
    end

    assign sum_w = acc_reg + ACC_W'(prod_reg);

    always_ff @(posedge aclk) begin
        prod_reg <= wrd_reg * hrd_reg;
        if (prod_v_reg) begin
            if (acc_first_reg)
                acc_reg <= (ACC_W'(brd_reg) <<< FRAC_BITS) + ACC_W'(prod_reg);
            else
                acc_reg <= sum_w;
        end
        if (fin_reg) begin
            och_reg   <= co_reg;
            ores_reg  <= acc_reg[FRAC_BITS +: 16];
            olast_reg <= 32'(co_reg) == CHANNELS - 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            co_reg <= '0; ci_reg <= '0; k_reg <= '0;
            rd_v_reg <= 1'b0; last_mac_reg <= 1'b0;
            prod_v_reg <= 1'b0; prod_last_reg <= 1'b0;
            acc_first_reg <= 1'b1; fin_reg <= 1'b0; ov_reg <= 1'b0;
        end else begin
            rd_v_reg      <= issue;
            last_mac_reg  <= end_issue;
            prod_v_reg    <= rd_v_reg;
            prod_last_reg <= last_mac_reg;
            fin_reg       <= 1'b0;
            if (prod_v_reg) acc_first_reg <= prod_last_reg;
            if (prod_v_reg && prod_last_reg) fin_reg <= 1'b1;
            if (fin_reg) ov_reg <= 1'b1;
            else if (m_valid && m_ready) ov_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE: begin
                    if (q_valid && q_cmd.kind == CMD_SAMPLE
                        && 32'(q_cmd.in_chan) == CHANNELS - 1) begin
                        st_reg <= ST_MAC;
                        co_reg <= '0; ci_reg <= '0; k_reg <= '0;
                    end
                end
                ST_MAC: begin
                    if (32'(k_reg) == KERNEL - 1) begin
                        k_reg <= '0;
                        if (32'(ci_reg) == CHANNELS - 1) begin
                            ci_reg <= '0;
                            st_reg <= ST_DONE;
                        end else ci_reg <= ci_reg + 3'd1;
                    end else k_reg <= k_reg + 2'd1;
                end
                ST_DONE: begin
                    // wait for the result to be taken before the next channel
                    if (ov_reg && m_ready) begin
                        if (32'(co_reg) == CHANNELS - 1) st_reg <= ST_SHFT;
                        else begin
                            co_reg <= co_reg + 3'd1;
                            st_reg <= ST_MAC;
                        end
                    end
                end
                ST_SHFT: st_reg <= ST_IDLE;
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = ov_reg;
    assign chan    = och_reg;
    assign result  = ores_reg;
    assign last    = olast_reg;
endmodule

// File: hw/rtl/causal_temporal_conv_unit.sv
// ----------------------------------------------------------------------------
// causal_temporal_conv_unit
// multichannel causal temporal convolution with bias
// ----------------------------------------------------------------------------
// s_ channel: one word per command, its kind in tuser: weight load, bias load
//   or sample; tdata {out_chan, in_chan, tap, value, seq_start} from bit 0 up
// m_ channel: one word per output channel once the last input channel of a
//   step has been received; tdata {chan, result} from bit 0 up, tlast on the final channel
// a front stage filters words and queues up to four commands; the back
//   stage runs one multiply-accumulate per cycle from the weight store
// load words and other samples are queued and are taken by the back stage
//   one per cycle while it is idle
// the last sample of a step starts the sequencer; for each output channel it
//   runs the multiply-accumulates over all input channels and taps, shows the
//   result word and waits until it is taken before the next channel; after
//   the top channel the history taps shift and the back stage goes idle;
//   m_tready low on a valid word stalls the busy back stage; the queue keeps
//   s_tready high until it fills
// reset clears the history taps and the control; weights and biases must
//   be loaded before use
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module causal_temporal_conv_unit import ctc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // out_chan, in_chan, tap, value, seq_start
    input  logic [1:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // chan, result
    output logic        m_tlast
);
    logic        q_valid, q_ready, busy;
    cmd_t        q_cmd;
    logic [2:0]  chan;
    logic [15:0] result;

    ctc_front u_front (
        .aclk, .aresetn,
        .s_valid(s_tvalid), .s_ready(s_tready),
        .action(s_tuser), .out_chan(s_tdata[2:0]), .in_chan(s_tdata[5:3]),
        .tap(s_tdata[7:6]), .value(s_tdata[23:8]), .seq_start(s_tdata[24]),
        .q_valid, .q_ready, .q_cmd
    );

    ctc_back u_back (
        .aclk, .aresetn,
        .q_valid, .q_ready, .q_cmd,
        .m_valid(m_tvalid), .m_ready(m_tready),
        .chan, .result, .last(m_tlast), .busy
    );

    assign m_tdata = {5'd0, result, chan};

    // a result word is only shown while the sequencer is working
    `ASSERT_CLK(a_out_busy, aclk, aresetn, m_tvalid |-> busy)
    // last word always carries the top channel
    `ASSERT_CLK(a_last_chan, aclk, aresetn, (m_tvalid && m_tlast) |-> (32'(chan) == CHANNELS - 1))
    // queue is not popped while the sequencer runs
    `ASSERT_NEVER(a_no_pop_busy, aclk, aresetn, q_ready && busy)
endmodule
